// File: rtl/core/pbc_pkg.sv
// Shared constants, codes and interface structs for the partitioned block convolver.
// Used by pbc_mem, pbc_mac and the partitioned_block_convolver top level.
`default_nettype none

package pbc_pkg;

	// Storage sizing
	localparam int MAX_TAPS  = 1024;
	localparam int MAX_BLOCK = 256;
	localparam int CHANNELS  = 2;
	localparam int HIST_LEN  = MAX_TAPS + MAX_BLOCK;

	localparam int TAP_W        = $clog2(MAX_TAPS);
	localparam int TCNT_W       = $clog2(MAX_TAPS + 1);
	localparam int HIST_W       = $clog2(HIST_LEN);
	localparam int FILL_W       = $clog2(HIST_LEN + 1);
	localparam int BLK_W        = $clog2(MAX_BLOCK + 1);
	localparam int BLK_LOG2_MAX = $clog2(MAX_BLOCK);

	// Field widths
	localparam int COEF_W     = 18;
	localparam int SAMP_W     = 24;
	localparam int PROD_W     = COEF_W + SAMP_W;
	localparam int ACC_W      = PROD_W + TAP_W + 1;
	localparam int FRAC_SHIFT = 17;

	localparam int BL_W = 4;
	localparam int TC_W = 11;
	localparam int CH_W = 2;

	localparam int S_TDATA_W  = 80;
	localparam int M_TDATA_W  = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd2;

	localparam logic [BL_W-1:0] BLOCK_LOG2_RST = 4'd6;
	localparam logic [TC_W-1:0] TAP_COUNT_RST  = 11'd1024;
	localparam logic [CH_W-1:0] CHANNELS_RST   = 2'd2;

	// Request kinds
	localparam logic KIND_COEF  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	// Memory access request from the sequencer
	typedef struct packed {
		logic              coef_we;
		logic              coef_both;
		logic              coef_ch;
		logic [TAP_W-1:0]  coef_waddr;
		logic [COEF_W-1:0] coef_wdata;
		logic              hist_we;
		logic [HIST_W-1:0] hist_waddr;
		logic [SAMP_W-1:0] hist_wdata0;
		logic [SAMP_W-1:0] hist_wdata1;
		logic              rd_en;
		logic [TAP_W-1:0]  coef_raddr;
		logic [HIST_W-1:0] hist_raddr;
		logic              hist_ok;
	} mem_req_t;

	// Registered read data toward the MAC unit
	typedef struct packed {
		logic              valid;
		logic [COEF_W-1:0] coef0;
		logic [COEF_W-1:0] coef1;
		logic [SAMP_W-1:0] samp0;
		logic [SAMP_W-1:0] samp1;
	} mem_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/pbc_mem.sv
// Coefficient and sample history memories with registered read ports.
// Depends on pbc_pkg for sizes and the request/response structs.
`default_nettype none

module pbc_mem (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pbc_pkg::mem_req_t req,
	output pbc_pkg::mem_rsp_t      rsp
);

	logic [pbc_pkg::COEF_W-1:0]   coef0_mem [pbc_pkg::MAX_TAPS];
	logic [pbc_pkg::COEF_W-1:0]   coef1_mem [pbc_pkg::MAX_TAPS];
	logic [2*pbc_pkg::SAMP_W-1:0] hist_mem  [pbc_pkg::HIST_LEN];

	logic [pbc_pkg::COEF_W-1:0]   coef0_q;
	logic [pbc_pkg::COEF_W-1:0]   coef1_q;
	logic [2*pbc_pkg::SAMP_W-1:0] hist_q;
	logic                         ok_q;
	logic                         valid_q;

	always_ff @(posedge clk) begin
		if (req.coef_we && (req.coef_both || !req.coef_ch)) begin
			coef0_mem[req.coef_waddr] <= req.coef_wdata;
		end
		if (req.coef_we && (req.coef_both || req.coef_ch)) begin
			coef1_mem[req.coef_waddr] <= req.coef_wdata;
		end
		if (req.hist_we) begin
			hist_mem[req.hist_waddr] <= {req.hist_wdata1, req.hist_wdata0};
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			coef0_q <= coef0_mem[req.coef_raddr];
			coef1_q <= coef1_mem[req.coef_raddr];
			hist_q  <= hist_mem[req.hist_raddr];
			ok_q    <= req.hist_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= req.rd_en;
		end
	end

	// History slots not yet written read as zero
	always_comb begin
		rsp.valid = valid_q;
		rsp.coef0 = coef0_q;
		rsp.coef1 = coef1_q;
		rsp.samp0 = ok_q ? hist_q[pbc_pkg::SAMP_W-1:0] : '0;
		rsp.samp1 = ok_q ? hist_q[2*pbc_pkg::SAMP_W-1:pbc_pkg::SAMP_W] : '0;
	end

endmodule

`default_nettype wire

// File: rtl/core/pbc_mac.sv
// Two-lane multiply-accumulate unit with round-half-up and saturation to Q1.23.
// Depends on pbc_pkg for widths and the memory response struct.
`default_nettype none

module pbc_mac (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pbc_pkg::mem_rsp_t          rsp,
	input  wire logic                       clr,
	output logic [pbc_pkg::SAMP_W-1:0]      y0,
	output logic [pbc_pkg::SAMP_W-1:0]      y1,
	output logic [1:0]                      sat,
	output logic                            busy
);

	localparam logic signed [pbc_pkg::ACC_W:0] RND =
		(pbc_pkg::ACC_W+1)'(2**(pbc_pkg::FRAC_SHIFT-1));
	localparam logic signed [pbc_pkg::ACC_W:0] YMAX =
		(pbc_pkg::ACC_W+1)'(2**(pbc_pkg::SAMP_W-1) - 1);
	localparam logic signed [pbc_pkg::ACC_W:0] YMIN =
		(pbc_pkg::ACC_W+1)'(-(2**(pbc_pkg::SAMP_W-1)));

	logic signed [pbc_pkg::PROD_W-1:0] prod_s2 [2];
	logic                              prod_v_s2;
	logic signed [pbc_pkg::ACC_W-1:0]  acc_q [2];
	logic signed [pbc_pkg::ACC_W:0]    rsum [2];
	logic signed [pbc_pkg::ACC_W:0]    rsh [2];
	logic [pbc_pkg::SAMP_W-1:0]        yv [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
		end else begin
			prod_v_s2 <= rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.valid) begin
			prod_s2[0] <= $signed(rsp.coef0) * $signed(rsp.samp0);
			prod_s2[1] <= $signed(rsp.coef1) * $signed(rsp.samp1);
		end
		if (clr) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
		end else if (prod_v_s2) begin
			acc_q[0] <= acc_q[0] + pbc_pkg::ACC_W'(prod_s2[0]);
			acc_q[1] <= acc_q[1] + pbc_pkg::ACC_W'(prod_s2[1]);
		end
	end

	// Round half up, drop the fraction, clamp to the output range
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rsum[i] = (pbc_pkg::ACC_W+1)'(acc_q[i]) + RND;
			rsh[i]  = rsum[i] >>> pbc_pkg::FRAC_SHIFT;
			if (rsh[i] > YMAX) begin
				yv[i]  = YMAX[pbc_pkg::SAMP_W-1:0];
				sat[i] = 1'b1;
			end else if (rsh[i] < YMIN) begin
				yv[i]  = YMIN[pbc_pkg::SAMP_W-1:0];
				sat[i] = 1'b1;
			end else begin
				yv[i]  = rsh[i][pbc_pkg::SAMP_W-1:0];
				sat[i] = 1'b0;
			end
		end
	end

	assign y0   = yv[0];
	assign y1   = yv[1];
	assign busy = prod_v_s2;

endmodule

`default_nettype wire

// File: rtl/core/partitioned_block_convolver.sv
// Top level of the partitioned block convolver: config registers, tap sequencer, result register.
// Depends on pbc_pkg, pbc_mem (coefficient and history memories) and pbc_mac (shared MAC).
//
// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------------------------
// s_*       s_tvalid / s_tready  tuser: kind; tdata: channel, index, coef, sample ch0, ch1
// m_*       m_tvalid / m_tready  tdata: out_ch0, out_ch1; tuser: saturated
// cfg_*     cfg_valid/cfg_ready  cfg_index selects register, cfg_data holds its value
//
// A coefficient request is written in the cycle it is accepted. A frame request reads taps
// rows, where taps is min(tap_count, 1024), then drains and completes; with no taps it skips
// the reads. One MAC lane per channel consumes one coefficient and one history row per cycle
// from the single read port of each memory, then the read and product stages drain.
// After reset a pass clears the coefficient memory; s_tready stays low meanwhile.
// Unwritten history slots read as zero through a fill count, so history needs no clearing.
// The result register frees the input side; a finished frame holds only while the previous
// result is still waiting on m_tready. cfg_ready is always high.
`default_nettype none

module partitioned_block_convolver (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [0] coef_channel, [10:1] coef_index, [28:11] coef_value,
	// [52:29] sample_ch0, [76:53] sample_ch1, [79:77] zero
	input  wire logic [pbc_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] kind
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [23:0] out_ch0, [47:24] out_ch1
	output logic [pbc_pkg::M_TDATA_W-1:0]          m_tdata,
	// [1:0] saturated
	output logic [1:0]                             m_tuser,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pbc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Unpacked request fields
	logic                        in_kind;
	logic                        in_coef_channel;
	logic [pbc_pkg::TAP_W-1:0]   in_coef_index;
	logic [pbc_pkg::COEF_W-1:0]  in_coef_value;
	logic [pbc_pkg::SAMP_W-1:0]  in_sample_ch0;
	logic [pbc_pkg::SAMP_W-1:0]  in_sample_ch1;

	// Configuration registers
	logic [pbc_pkg::BL_W-1:0]    block_log2_q;
	logic [pbc_pkg::TC_W-1:0]    tap_count_q;
	logic [pbc_pkg::CH_W-1:0]    channels_in_use_q;

	// Sequencer state
	state_t                      state_q;
	logic [pbc_pkg::TAP_W-1:0]   clr_q;
	logic [pbc_pkg::TCNT_W-1:0]  tap_q;
	logic [pbc_pkg::TCNT_W-1:0]  taps_q;
	logic [pbc_pkg::HIST_W-1:0]  rd_q;
	logic [pbc_pkg::HIST_W-1:0]  ptr_q;
	logic [pbc_pkg::FILL_W-1:0]  fill_q;
	logic                        ch1_q;

	// Result register
	logic                        m_tvalid_q;
	logic [pbc_pkg::SAMP_W-1:0]  out_ch0_q;
	logic [pbc_pkg::SAMP_W-1:0]  out_ch1_q;
	logic [1:0]                  sat_q;

	// Derived values
	logic                        s_accept;
	logic                        frame_accept;
	logic [pbc_pkg::BLK_W-1:0]   blk;
	logic [pbc_pkg::TCNT_W-1:0]  taps_eff;
	logic                        ch1_on;
	logic [pbc_pkg::HIST_W:0]    start_sum;
	logic [pbc_pkg::HIST_W-1:0]  start_addr;

	pbc_pkg::mem_req_t           req;
	pbc_pkg::mem_rsp_t           rsp;
	logic [pbc_pkg::SAMP_W-1:0]  mac_y0;
	logic [pbc_pkg::SAMP_W-1:0]  mac_y1;
	logic [1:0]                  mac_sat;
	logic                        mac_busy;

	assign in_kind         = s_tuser;
	assign in_coef_channel = s_tdata[0];
	assign in_coef_index   = s_tdata[10:1];
	assign in_coef_value   = s_tdata[28:11];
	assign in_sample_ch0   = s_tdata[52:29];
	assign in_sample_ch1   = s_tdata[76:53];

	assign s_tready     = (state_q == ST_IDLE);
	assign s_accept     = s_tvalid && s_tready;
	assign frame_accept = s_accept && (in_kind == pbc_pkg::KIND_FRAME);

	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_log2_q      <= pbc_pkg::BLOCK_LOG2_RST;
			tap_count_q       <= pbc_pkg::TAP_COUNT_RST;
			channels_in_use_q <= pbc_pkg::CHANNELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pbc_pkg::REG_BLOCK_LOG2: block_log2_q      <= cfg_data[pbc_pkg::BL_W-1:0];
				pbc_pkg::REG_TAP_COUNT:  tap_count_q       <= cfg_data[pbc_pkg::TC_W-1:0];
				pbc_pkg::REG_CHANNELS:   channels_in_use_q <= cfg_data[pbc_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Block size saturates at the largest block; tap count at the coefficient depth
	always_comb begin
		if (32'(block_log2_q) > pbc_pkg::BLK_LOG2_MAX) begin
			blk = pbc_pkg::BLK_W'(pbc_pkg::MAX_BLOCK);
		end else begin
			blk = pbc_pkg::BLK_W'(1) << block_log2_q;
		end
		if (32'(tap_count_q) > pbc_pkg::MAX_TAPS) begin
			taps_eff = pbc_pkg::TCNT_W'(pbc_pkg::MAX_TAPS);
		end else begin
			taps_eff = pbc_pkg::TCNT_W'(tap_count_q);
		end
	end

	// Zero and one both mean a single channel; two and three mean both
	assign ch1_on = (channels_in_use_q >= pbc_pkg::CH_W'(2));

	// First history slot to read: one block behind the slot being written
	assign start_sum  = (pbc_pkg::HIST_W+1)'(ptr_q) + (pbc_pkg::HIST_W+1)'(pbc_pkg::HIST_LEN)
	                  - (pbc_pkg::HIST_W+1)'(blk);
	assign start_addr = (32'(start_sum) >= pbc_pkg::HIST_LEN)
	                  ? pbc_pkg::HIST_W'(start_sum - (pbc_pkg::HIST_W+1)'(pbc_pkg::HIST_LEN))
	                  : start_sum[pbc_pkg::HIST_W-1:0];

	// Memory requests for the current state
	always_comb begin
		req = '0;
		case (state_q)
			ST_CLEAR: begin
				req.coef_we    = 1'b1;
				req.coef_both  = 1'b1;
				req.coef_waddr = clr_q;
			end
			ST_IDLE: begin
				if (s_accept && in_kind == pbc_pkg::KIND_COEF) begin
					req.coef_we    = 1'b1;
					req.coef_ch    = in_coef_channel;
					req.coef_waddr = in_coef_index;
					req.coef_wdata = in_coef_value;
				end
				if (frame_accept) begin
					req.hist_we     = 1'b1;
					req.hist_waddr  = ptr_q;
					req.hist_wdata0 = in_sample_ch0;
					req.hist_wdata1 = ch1_on ? in_sample_ch1 : '0;
				end
			end
			ST_RUN: begin
				req.rd_en      = 1'b1;
				req.coef_raddr = tap_q[pbc_pkg::TAP_W-1:0];
				req.hist_raddr = rd_q;
				req.hist_ok    = (pbc_pkg::FILL_W'(rd_q) < fill_q);
			end
			default: ;
		endcase
	end

	pbc_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	pbc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.rsp    (rsp),
		.clr    (frame_accept),
		.y0     (mac_y0),
		.y1     (mac_y1),
		.sat    (mac_sat),
		.busy   (mac_busy)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			tap_q      <= '0;
			taps_q     <= '0;
			rd_q       <= '0;
			ptr_q      <= '0;
			fill_q     <= '0;
			ch1_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_ch0_q  <= '0;
			out_ch1_q  <= '0;
			sat_q      <= '0;
		end else begin
			// Drop the result once the consumer takes it, unless a new one loads now
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + pbc_pkg::TAP_W'(1);
					if (clr_q == pbc_pkg::TAP_W'(pbc_pkg::MAX_TAPS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (frame_accept) begin
						ptr_q  <= (ptr_q == pbc_pkg::HIST_W'(pbc_pkg::HIST_LEN - 1))
						        ? '0 : ptr_q + pbc_pkg::HIST_W'(1);
						if (fill_q != pbc_pkg::FILL_W'(pbc_pkg::HIST_LEN)) begin
							fill_q <= fill_q + pbc_pkg::FILL_W'(1);
						end
						ch1_q  <= ch1_on;
						taps_q <= taps_eff;
						tap_q  <= '0;
						rd_q   <= start_addr;
						state_q <= (taps_eff == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					tap_q <= tap_q + pbc_pkg::TCNT_W'(1);
					rd_q  <= (rd_q == '0) ? pbc_pkg::HIST_W'(pbc_pkg::HIST_LEN - 1)
					       : rd_q - pbc_pkg::HIST_W'(1);
					if (tap_q + pbc_pkg::TCNT_W'(1) == taps_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Wait for the last read and product to land in the accumulators
					if (!rsp.valid && !mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_ch0_q  <= mac_y0;
						out_ch1_q  <= ch1_q ? mac_y1 : '0;
						sat_q      <= {ch1_q & mac_sat[1], mac_sat[0]};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_ch1_q, out_ch0_q};
	assign m_tuser  = sat_q;

`ifndef SYNTHESIS
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> tap_q < taps_q)
		else $error("tap counter ran past the tap count");

	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == pbc_pkg::FILL_W'(pbc_pkg::HIST_LEN) || fill_q == pbc_pkg::FILL_W'(ptr_q))
		else $error("history fill count lost track of the write pointer");

	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $past(state_q == ST_RUN))
		else $error("memory read data without a tap issue");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented outside frame completion");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rsp.valid && !mac_busy)
		else $error("new request taken while the MAC pipeline still holds data");
`endif

endmodule

`default_nettype wire

// File: tb/sv/partitioned_block_convolver_test.sv
// Self-checking testbench for partitioned_block_convolver: streams coefficient and frame
// requests, predicts each delayed FIR output and compares it with the result stream.
// Depends on pbc_pkg and the partitioned_block_convolver RTL only.
`timescale 1ns / 1ps

module partitioned_block_convolver_test;

	// Unused register index; writes to it must be dropped by the block
	localparam logic [pbc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SQUEEZE_CYCLES = 2000;

	typedef struct {
		logic                       kind;
		logic                       chan;
		logic [pbc_pkg::TAP_W-1:0]  tap;
		logic [pbc_pkg::COEF_W-1:0] coef;
		logic [pbc_pkg::SAMP_W-1:0] s0;
		logic [pbc_pkg::SAMP_W-1:0] s1;
	} request_t;

	typedef struct {
		logic [pbc_pkg::SAMP_W-1:0] ch0;
		logic [pbc_pkg::SAMP_W-1:0] ch1;
		logic [1:0]                 sat;
	} output_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [pbc_pkg::S_TDATA_W-1:0]     s_tdata = '0;
	logic                              s_tuser = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [pbc_pkg::M_TDATA_W-1:0]     m_tdata;
	logic [1:0]                        m_tuser;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [pbc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [pbc_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

	// Mirror of the block: configuration, tap memory, sample ring and its write pointer
	logic [pbc_pkg::BL_W-1:0]          blk_log2_setting = pbc_pkg::BLOCK_LOG2_RST;
	logic [pbc_pkg::TC_W-1:0]          tap_setting = pbc_pkg::TAP_COUNT_RST;
	logic [pbc_pkg::CH_W-1:0]          chan_setting = pbc_pkg::CHANNELS_RST;
	int                                tap_mem [2][pbc_pkg::MAX_TAPS];
	int                                sample_ring [2][pbc_pkg::HIST_LEN];
	int                                ring_ptr = 0;

	request_t                          request_queue[$];
	output_t                           pending_outputs[$];
	request_t                          next_req;
	bit                                s_taken = 1'b0;
	int                                send_idle_pct = 26;
	int                                recv_idle_pct = 26;
	bit                                squeeze_req = 1'b0;
	bit                                squeeze_done = 1'b0;
	int                                hold_left = 0;
	int                                err_count = 0;
	int                                cycle_count = 0;

	partitioned_block_convolver DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Store one frame in the ring and form the output delayed by one block.
	// Every product is exact; the sum rounds half up to Q1.23 and then clips.
	function automatic output_t convolve_frame(logic signed [pbc_pkg::SAMP_W-1:0] in0,
	                                           logic signed [pbc_pkg::SAMP_W-1:0] in1);
		output_t res;
		int      nch, blk, taps, slot, ch, k;
		longint  acc, y;
		res.ch0 = '0;
		res.ch1 = '0;
		res.sat = '0;
		// Clamp the settings the same way the block does
		nch = (chan_setting == 0) ? 1 : ((chan_setting > 2) ? 2 : int'(chan_setting));
		blk = (blk_log2_setting > pbc_pkg::BLK_LOG2_MAX) ? pbc_pkg::MAX_BLOCK
		                                                 : (1 << blk_log2_setting);
		taps = (tap_setting > pbc_pkg::MAX_TAPS) ? pbc_pkg::MAX_TAPS : int'(tap_setting);
		for (ch = 0; ch < 2; ch++) begin
			// An inactive channel writes zero into its history
			if (ch >= nch)
				sample_ring[ch][ring_ptr] = 0;
			else if (ch == 0)
				sample_ring[ch][ring_ptr] = int'(in0);
			else
				sample_ring[ch][ring_ptr] = int'(in1);
			if (ch < nch) begin
				acc = 0;
				for (k = 0; k < taps; k++) begin
					slot = (ring_ptr + pbc_pkg::HIST_LEN - blk - k) % pbc_pkg::HIST_LEN;
					acc += longint'(tap_mem[ch][k]) * longint'(sample_ring[ch][slot]);
				end
				y = (acc + 64'sd65536) >>> pbc_pkg::FRAC_SHIFT;
				if (y > 64'sd8388607) begin
					y = 64'sd8388607;
					res.sat[ch] = 1'b1;
				end else if (y < -64'sd8388608) begin
					y = -64'sd8388608;
					res.sat[ch] = 1'b1;
				end
				if (ch == 0)
					res.ch0 = y[pbc_pkg::SAMP_W-1:0];
				else
					res.ch1 = y[pbc_pkg::SAMP_W-1:0];
			end
		end
		ring_ptr = (ring_ptr + 1) % pbc_pkg::HIST_LEN;
		return res;
	endfunction

	// Half the time extremes and small values of either sign, otherwise any bit pattern
	function automatic logic [31:0] pick_value(int w);
		logic [31:0] v;
		case ($urandom_range(7))
			0:       v = (32'd1 << (w - 1)) - 32'd1;
			1:       v = 32'd1 << (w - 1);
			2:       v = $urandom_range(255);
			3:       v = -$urandom_range(256);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Every field gets random content, even those the request kind ignores
	function automatic request_t rand_request(int tap_hint);
		request_t    r;
		logic [31:0] v;
		r.kind = ($urandom_range(3) == 0) ? pbc_pkg::KIND_COEF : pbc_pkg::KIND_FRAME;
		r.chan = 1'($urandom_range(1));
		// Aim most taps at the ones in use, some anywhere in the memory
		r.tap = ($urandom_range(3) == 0)
		      ? pbc_pkg::TAP_W'($urandom_range(pbc_pkg::MAX_TAPS - 1))
		      : pbc_pkg::TAP_W'($urandom_range(tap_hint - 1));
		v = pick_value(pbc_pkg::COEF_W);
		r.coef = v[pbc_pkg::COEF_W-1:0];
		v = pick_value(pbc_pkg::SAMP_W);
		r.s0 = v[pbc_pkg::SAMP_W-1:0];
		v = pick_value(pbc_pkg::SAMP_W);
		r.s1 = v[pbc_pkg::SAMP_W-1:0];
		return r;
	endfunction

	task automatic push_coef(logic chan, logic [pbc_pkg::TAP_W-1:0] tap,
	                         logic [pbc_pkg::COEF_W-1:0] value);
		request_t r;
		r.kind = pbc_pkg::KIND_COEF;
		r.chan = chan;
		r.tap = tap;
		r.coef = value;
		r.s0 = '0;
		r.s1 = '0;
		request_queue.push_back(r);
	endtask

	task automatic push_frame(logic [pbc_pkg::SAMP_W-1:0] s0, logic [pbc_pkg::SAMP_W-1:0] s1);
		request_t r;
		r.kind = pbc_pkg::KIND_FRAME;
		r.chan = 1'b0;
		r.tap = '0;
		r.coef = '0;
		r.s0 = s0;
		r.s1 = s1;
		request_queue.push_back(r);
	endtask

	// Write one register and mirror it once the handshake completes
	task automatic write_reg(logic [pbc_pkg::CFG_IDX_W-1:0] idx,
	                         logic [pbc_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			pbc_pkg::REG_BLOCK_LOG2: blk_log2_setting = value[pbc_pkg::BL_W-1:0];
			pbc_pkg::REG_TAP_COUNT:  tap_setting = value[pbc_pkg::TC_W-1:0];
			pbc_pkg::REG_CHANNELS:   chan_setting = value[pbc_pkg::CH_W-1:0];
			default:                 ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every request went in and every output came back, then let a
	// trailing coefficient request finish before the registers change
	task automatic drain();
		while (request_queue.size() != 0 || s_tvalid || pending_outputs.size() != 0)
			@(posedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic run_phase(int n, int tap_hint);
		for (int i = 0; i < n; i++)
			request_queue.push_back(rand_request(tap_hint));
		drain();
	endtask

	// Sender: offer the next request or idle; hold a request until it is taken
	always @(negedge clk) begin
		if (!s_tvalid || s_taken) begin
			if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_req.kind;
				s_tdata <= {3'b000, next_req.s1, next_req.s0, next_req.coef,
				            next_req.tap, next_req.chan};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		s_taken = 1'b0;
	end

	// Receiver: random backpressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (squeeze_req && !squeeze_done) begin
			hold_left = SQUEEZE_CYCLES;
			squeeze_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Accepted requests: update the tap mirror or predict the frame's output
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s_taken = 1'b1;
			if (s_tuser == pbc_pkg::KIND_COEF)
				tap_mem[s_tdata[0]][s_tdata[10:1]] = int'($signed(s_tdata[28:11]));
			else
				pending_outputs.push_back(convolve_frame($signed(s_tdata[52:29]),
				                                         $signed(s_tdata[76:53])));
		end
	end

	// Accepted outputs: compare with the oldest prediction
	always @(posedge clk) begin
		output_t exp_out;
		if (m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0) begin
				$error("output with no frame pending: tdata %h tuser %h", m_tdata, m_tuser);
				err_count++;
			end else begin
				exp_out = pending_outputs.pop_front();
				if (m_tdata[23:0] !== exp_out.ch0) begin
					$error("out_ch0 expected %h got %h", exp_out.ch0, m_tdata[23:0]);
					err_count++;
				end
				if (m_tdata[47:24] !== exp_out.ch1) begin
					$error("out_ch1 expected %h got %h", exp_out.ch1, m_tdata[47:24]);
					err_count++;
				end
				if (m_tuser !== exp_out.sat) begin
					$error("saturated expected %b got %b", exp_out.sat, m_tuser);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("partitioned_block_convolver_test: errors");
			$finish;
		end
	end

	initial begin
		int ch, k;
		for (ch = 0; ch < 2; ch++) begin
			for (k = 0; k < pbc_pkg::MAX_TAPS; k++)
				tap_mem[ch][k] = 0;
			for (k = 0; k < pbc_pkg::HIST_LEN; k++)
				sample_ring[ch][k] = 0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Shortest block and a few taps so the directed frames show up at once
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd0);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd4);
		write_reg(pbc_pkg::REG_CHANNELS, 11'd2);
		push_coef(1'b0, 10'd0, 18'h1FFFF);      // largest positive tap
		push_coef(1'b0, 10'd1, 18'h1FFFF);
		push_coef(1'b1, 10'd0, 18'h20000);      // most negative tap
		push_coef(1'b1, 10'd2, 18'h10000);      // one half: exercises round half up
		push_coef(1'b1, 10'd1023, 18'h3FFFF);   // top index, beyond the taps in use
		push_coef(1'b0, 10'd1023, 18'h20000);
		push_coef(1'b0, 10'h2AA, 18'h15555);
		push_coef(1'b1, 10'h155, 18'h2AAAA);
		// Full-scale frames drive both channels into clipping, most negative
		// tap times most negative sample lands exactly one past the top
		push_frame(24'h7FFFFF, 24'h800000);
		push_frame(24'h7FFFFF, 24'h800000);
		push_frame(24'h800000, 24'h7FFFFF);
		push_frame(24'h800000, 24'h800000);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'hFFFFFF, 24'h000001);
		push_frame(24'h000001, 24'hFFFFFF);
		push_frame(24'h555555, 24'hAAAAAA);
		push_frame(24'hAAAAAA, 24'h555555);
		push_coef(1'b0, 10'd3, 18'h00001);      // smallest tap
		push_coef(1'b1, 10'd3, 18'h3FFFF);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'h000000, 24'h000000);
		push_frame(24'h123456, 24'hEDCBA9);
		push_frame(24'h000000, 24'h000000);
		drain();

		// Largest block and full tap length: the slow end of the range
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd8);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd1024);
		run_phase(30, pbc_pkg::MAX_TAPS);

		// Settings above their limits clamp to the largest legal values
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd15);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd2047);
		write_reg(pbc_pkg::REG_CHANNELS, 11'd3);
		run_phase(20, pbc_pkg::MAX_TAPS);

		// No taps and zero channels: all outputs zero, one channel active
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd2);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd0);
		write_reg(pbc_pkg::REG_CHANNELS, 11'd0);
		run_phase(30, 1);

		// Single channel, no idling on either side; the spare index is ignored
		write_reg(REG_SPARE, 11'h7FF);
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd3);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd16);
		write_reg(pbc_pkg::REG_CHANNELS, 11'd1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(100, 16);
		send_idle_pct = 26;
		recv_idle_pct = 26;

		// Both channels back, with one long output stall to back up the input
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd1);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd24);
		write_reg(pbc_pkg::REG_CHANNELS, 11'd2);
		squeeze_req = 1'b1;
		run_phase(200, 24);

		// Single tap, the shortest filter
		write_reg(pbc_pkg::REG_BLOCK_LOG2, 11'd4);
		write_reg(pbc_pkg::REG_TAP_COUNT, 11'd1);
		run_phase(180, 1);

		repeat (32) @(negedge clk);
		if (err_count == 0)
			$display("partitioned_block_convolver_test: clean");
		else
			$display("partitioned_block_convolver_test: errors");
		$finish;
	end

endmodule
